// ----- hw/rtl/register_write_delta_encoder_macros.svh -----
// Assertion macros for the register write delta encoder.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef REGISTER_WRITE_DELTA_ENCODER_MACROS_SVH
`define REGISTER_WRITE_DELTA_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is high
`define RWDE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that also runs through reset
`define RWDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RWDE_ASSERT(lbl, clk, rst, prop, msg)
`define RWDE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/rwde_pkg.sv -----
// Shared types, constants and helpers of the register write delta encoder.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package rwde_pkg;

   // Shadow store geometry (depth must be a power of two)
   localparam int SHADOW_DEPTH = 1024;
   localparam int ADDR_W       = $clog2(SHADOW_DEPTH);

   // Epoch tags mark which restart generation wrote an entry
   localparam int EPOCH_W = 6;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_LOCK  = EPOCH_MAX - EPOCH_W'(1);

   // Gap encoding constants
   localparam logic [14:0] GAP_UNIT    = 15'h7fff;
   localparam logic [16:0] GAP_UNIT_X1 = {2'b00, GAP_UNIT};
   localparam logic [16:0] GAP_UNIT_X2 = GAP_UNIT_X1 + GAP_UNIT_X1;
   localparam logic [16:0] GAP_UNIT_X3 = GAP_UNIT_X2 + GAP_UNIT_X1;
   localparam logic [15:0] DELTA_FLAG  = 16'h8000;
   localparam logic [15:0] QUANT_STEP  = 16'd1000;
   localparam logic [3:0]  EARLY_LIMIT = 4'd10;
   localparam int          OP_REG_BITS = 7;

   typedef struct packed {
      logic        armed;
      logic [9:0]  reg_index;
      logic [7:0]  reg_value;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      logic [16:0] filler_count;
      logic        delta_present;
      logic [15:0] delta_word;
      logic [14:0] op_word;
      logic        restarted;
   } rsp_type;

   // One shadow entry: generation tag plus stored byte
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [7:0]         value;
   } entry_type;

   // Outcome of the gap arithmetic for one changed write
   typedef struct packed {
      logic        restart;
      logic [16:0] filler_count;
      logic        delta_present;
      logic [15:0] delta_word;
      logic [30:0] time_base;
      logic [3:0]  early_cnt;
   } calc_type;

   // Sweep sequencer view of the shadow RAM ports
   typedef struct packed {
      logic              busy;
      logic              done;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
   } sweep_type;

   // Register index folded onto the store depth
   function automatic logic [ADDR_W-1:0] slot_of(input logic [9:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rwde_shadow_ram.sv -----
// Shadow register store: one write port, one registered read port.
// Depends on rwde_pkg for depth and entry type.
`default_nettype none

module rwde_shadow_ram (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [rwde_pkg::ADDR_W-1:0] wr_addr,
   input  wire rwde_pkg::entry_type       wr_data,
   input  wire logic                      rd_en,
   input  wire logic [rwde_pkg::ADDR_W-1:0] rd_addr,
   output rwde_pkg::entry_type            rd_data
);

   rwde_pkg::entry_type mem [rwde_pkg::SHADOW_DEPTH];
   rwde_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rwde_gap_calc.sv -----
// Gap arithmetic: filler count in closed form, delta word, next time base
// and early word count. Depends on rwde_pkg.
`default_nettype none

module rwde_gap_calc (
   input  wire logic [30:0] half,
   input  wire logic [30:0] time_base,
   input  wire logic [3:0]  early_cnt,
   input  wire logic        quantize_enable,
   output rwde_pkg::calc_type calc
);

   logic [31:0] diff;
   logic        is_neg;
   logic        is_long;
   logic        restart;
   logic [30:0] gap_m1;
   logic [16:0] fold;
   logic [16:0] fold_rem;
   logic [1:0]  fold_q;
   logic [16:0] fillers;
   logic [15:0] remain;
   logic [15:0] thresh;
   logic        present;
   logic [30:0] tb_fill;
   logic [3:0]  early_base;
   logic [4:0]  early_sum;

   always_comb begin
      // signed gap in half-ticks
      diff    = {1'b0, half} - {1'b0, time_base};
      is_neg  = diff[31];
      is_long = !is_neg && (diff[30:15] != '0);
      restart = is_long && (early_cnt < rwde_pkg::EARLY_LIMIT);

      // (gap-1)/0x7fff: x = a*2^15 + b = a*0x7fff + (a+b), then fold a+b
      gap_m1 = half + ~time_base;
      fold   = {1'b0, gap_m1[30:15]} + {2'b00, gap_m1[14:0]};
      if (fold >= rwde_pkg::GAP_UNIT_X3) begin
         fold_q   = 2'd3;
         fold_rem = fold - rwde_pkg::GAP_UNIT_X3;
      end else if (fold >= rwde_pkg::GAP_UNIT_X2) begin
         fold_q   = 2'd2;
         fold_rem = fold - rwde_pkg::GAP_UNIT_X2;
      end else if (fold >= rwde_pkg::GAP_UNIT_X1) begin
         fold_q   = 2'd1;
         fold_rem = fold - rwde_pkg::GAP_UNIT_X1;
      end else begin
         fold_q   = 2'd0;
         fold_rem = fold;
      end

      // fillers and remaining gap
      fillers = '0;
      remain  = '0;
      tb_fill = time_base;
      if (is_long && !restart) begin
         fillers = {1'b0, gap_m1[30:15]} + 17'(fold_q);
         remain  = {1'b0, fold_rem[14:0]} + 16'd1;
         tb_fill = half - {15'b0, remain};
      end else if (!is_neg && !is_long) begin
         remain = diff[15:0];
      end

      // delta word only above the threshold
      thresh  = quantize_enable ? rwde_pkg::QUANT_STEP : '0;
      present = remain > thresh;

      // early word count, saturating
      early_base = restart ? '0 : early_cnt;
      early_sum  = {1'b0, early_base} + {1'b0, fillers[3:0]} + {4'b0, present} + 5'd1;

      calc.restart       = restart;
      calc.filler_count  = fillers;
      calc.delta_present = present;
      calc.delta_word    = present ? (remain | rwde_pkg::DELTA_FLAG) : '0;
      calc.time_base     = (restart || present) ? half : tb_fill;
      if ((fillers[16:4] != '0) || (early_sum >= {1'b0, rwde_pkg::EARLY_LIMIT})) begin
         calc.early_cnt = rwde_pkg::EARLY_LIMIT;
      end else begin
         calc.early_cnt = early_sum[3:0];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rwde_sweep.sv -----
// Sweep sequencer over the shadow RAM: clears all tags after reset and
// retags the live generation when the epoch counter runs out. Uses rwde_pkg.
`default_nettype none

module rwde_sweep (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rwde_pkg::EPOCH_W-1:0] epoch,
   input  wire rwde_pkg::entry_type          rd_data,
   output rwde_pkg::sweep_type               ctl
);

   logic                        busy_ff, busy_in;
   logic                        init_ff, init_in;
   logic [rwde_pkg::ADDR_W:0]   cnt_ff, cnt_in;
   logic                        wr_pend_ff, wr_pend_in;
   logic [rwde_pkg::ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic                        issue;
   logic                        last;

   assign issue = busy_ff && (cnt_ff < (rwde_pkg::ADDR_W + 1)'(rwde_pkg::SHADOW_DEPTH));
   assign last  = wr_pend_ff
                  && (wr_addr_ff == rwde_pkg::ADDR_W'(rwde_pkg::SHADOW_DEPTH - 1));

   // read one entry a cycle, write it back in the next cycle
   always_comb begin
      busy_in = busy_ff;
      init_in = init_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff && start) begin
         busy_in = 1'b1;
         init_in = 1'b0;
         cnt_in  = '0;
      end else begin
         if (issue) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
      wr_pend_in = issue;
      wr_addr_in = cnt_ff[rwde_pkg::ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         init_ff    <= 1'b1;
         cnt_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         init_ff    <= init_in;
         cnt_ff     <= cnt_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
   end

   // live entries move to the first epoch, everything else goes invalid
   always_comb begin
      ctl.busy          = busy_ff;
      ctl.done          = last;
      ctl.rd_en         = issue;
      ctl.rd_addr       = cnt_ff[rwde_pkg::ADDR_W-1:0];
      ctl.wr_en         = wr_pend_ff;
      ctl.wr_addr       = wr_addr_ff;
      ctl.wr_data.value = rd_data.value;
      if (!init_ff && (rd_data.tag == epoch)) begin
         ctl.wr_data.tag = rwde_pkg::EPOCH_FIRST;
      end else begin
         ctl.wr_data.tag = rwde_pkg::EPOCH_NONE;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/register_write_delta_encoder.sv -----
// Top level of the register write delta encoder: shadow compare pipeline,
// output register and config bit. Uses rwde_pkg, rwde_shadow_ram,
// rwde_gap_calc, rwde_sweep and the assertion macro header.
//
//   channel   dir  handshake              beat
//   req_      in   req_valid/req_ready    req_data  (rwde_pkg::req_type)
//   rsp_      out  rsp_valid/rsp_ready    rsp_data  (rwde_pkg::rsp_type)
//   csr_      in   csr_wr_en              csr_wr_data (quantize enable)
//
// One write per cycle sustained while rsp_ready is high: a beat reads its shadow slot
// on accept and compares, encodes and writes back in the registered compare stage;
// a write to the same slot in the read cycle is forwarded. rsp_valid rises only for
// a changed write, registered from the compare stage. After reset a clearing pass
// runs with req_ready low. After 61 restarts the input drains, then a retag pass
// holds it. A stalled rsp beat holds the compare stage; req_ready follows rsp_ready.
`default_nettype none

`include "register_write_delta_encoder_macros.svh"

module register_write_delta_encoder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire rwde_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rwde_pkg::rsp_type rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data
);

   logic                         quant_ff;
   logic                         s1_valid_ff, s1_valid_in;
   rwde_pkg::req_type            s1_req_ff;
   logic                         byp_hit_ff, byp_hit_in;
   rwde_pkg::entry_type          byp_entry_ff;
   logic [rwde_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [30:0]                  time_base_ff, time_base_in;
   logic [3:0]                   early_cnt_ff, early_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rwde_pkg::rsp_type            rsp_data_ff;

   logic                         req_accept;
   logic                         out_free;
   logic                         commit;
   logic [rwde_pkg::ADDR_W-1:0]  req_slot;
   logic [rwde_pkg::ADDR_W-1:0]  pipe_slot;
   rwde_pkg::entry_type          entry;
   logic                         hit;
   logic                         changed;
   logic                         pipe_wr_en;
   rwde_pkg::entry_type          pipe_wr_entry;
   logic [rwde_pkg::EPOCH_W-1:0] epoch_bumped;
   logic [30:0]                  half;
   rwde_pkg::calc_type           calc;
   rwde_pkg::sweep_type          sweep_ctl;
   logic                         sweep_start;
   logic                         ram_wr_en;
   logic [rwde_pkg::ADDR_W-1:0]  ram_wr_addr;
   rwde_pkg::entry_type          ram_wr_data;
   logic                         ram_rd_en;
   logic [rwde_pkg::ADDR_W-1:0]  ram_rd_addr;
   rwde_pkg::entry_type          ram_rd_data;

   // handshakes
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign commit      = s1_valid_ff && out_free;
   assign req_ready   = (!s1_valid_ff || out_free) && !sweep_ctl.busy
                        && (epoch_ff < rwde_pkg::EPOCH_LOCK);
   assign req_accept  = req_valid && req_ready;
   assign sweep_start = !sweep_ctl.busy && !s1_valid_ff && (epoch_ff >= rwde_pkg::EPOCH_LOCK);

   assign req_slot  = rwde_pkg::slot_of(req_data.reg_index);
   assign pipe_slot = rwde_pkg::slot_of(s1_req_ff.reg_index);

   // compare stage: forwarded entry wins over RAM data
   assign entry        = byp_hit_ff ? byp_entry_ff : ram_rd_data;
   assign hit          = (entry.tag == epoch_ff) && (entry.value == s1_req_ff.reg_value);
   assign changed      = s1_req_ff.armed && !hit;
   assign pipe_wr_en   = commit && changed;
   assign half         = s1_req_ff.time_now[31:1];
   assign epoch_bumped = epoch_ff + 1'b1;

   rwde_gap_calc u_gap_calc (
      .half            (half),
      .time_base       (time_base_ff),
      .early_cnt       (early_cnt_ff),
      .quantize_enable (quant_ff),
      .calc            (calc)
   );

   assign pipe_wr_entry.tag   = calc.restart ? epoch_bumped : epoch_ff;
   assign pipe_wr_entry.value = s1_req_ff.reg_value;

   // RAM port sharing between sweep and pipeline
   assign ram_wr_en   = sweep_ctl.busy ? sweep_ctl.wr_en   : pipe_wr_en;
   assign ram_wr_addr = sweep_ctl.busy ? sweep_ctl.wr_addr : pipe_slot;
   assign ram_wr_data = sweep_ctl.busy ? sweep_ctl.wr_data : pipe_wr_entry;
   assign ram_rd_en   = sweep_ctl.busy ? sweep_ctl.rd_en   : req_accept;
   assign ram_rd_addr = sweep_ctl.busy ? sweep_ctl.rd_addr : req_slot;

   rwde_shadow_ram u_shadow_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rwde_sweep u_sweep (
      .clock   (clock),
      .reset   (reset),
      .start   (sweep_start),
      .epoch   (epoch_ff),
      .rd_data (ram_rd_data),
      .ctl     (sweep_ctl)
   );

   // next state
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (commit) begin
         s1_valid_in = 1'b0;
      end

      byp_hit_in = pipe_wr_en && (pipe_slot == req_slot);

      epoch_in     = epoch_ff;
      time_base_in = time_base_ff;
      early_cnt_in = early_cnt_ff;
      if (sweep_ctl.done) begin
         epoch_in = rwde_pkg::EPOCH_FIRST;
      end else if (pipe_wr_en) begin
         time_base_in = calc.time_base;
         early_cnt_in = calc.early_cnt;
         if (calc.restart) begin
            epoch_in = epoch_bumped;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (pipe_wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         epoch_ff     <= rwde_pkg::EPOCH_FIRST;
         time_base_ff <= '0;
         early_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            quant_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         epoch_ff     <= epoch_in;
         time_base_ff <= time_base_in;
         early_cnt_ff <= early_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff    <= req_data;
         byp_hit_ff   <= byp_hit_in;
         byp_entry_ff <= pipe_wr_entry;
      end
      if (pipe_wr_en) begin
         rsp_data_ff.filler_count  <= calc.filler_count;
         rsp_data_ff.delta_present <= calc.delta_present;
         rsp_data_ff.delta_word    <= calc.delta_word;
         rsp_data_ff.op_word       <= {s1_req_ff.reg_index[rwde_pkg::OP_REG_BITS-1:0],
                                       s1_req_ff.reg_value};
         rsp_data_ff.restarted     <= calc.restart;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `RWDE_ASSERT_ALWAYS(a_reset_quiet, clock,
      reset |=> (!rsp_valid && !req_ready), "outputs active right after reset")
   `RWDE_ASSERT(a_sweep_owns_ram, clock, reset,
      sweep_ctl.busy |-> !pipe_wr_en, "pipeline write during sweep")
   `RWDE_ASSERT(a_restart_bare, clock, reset,
      (rsp_valid && rsp_data.restarted) |->
         ((rsp_data.filler_count == '0) && !rsp_data.delta_present),
      "restart beat carries gap words")
   `RWDE_ASSERT(a_restart_state, clock, reset,
      (pipe_wr_en && calc.restart) |=>
         ((early_cnt_ff == 4'd1) && (time_base_ff == $past(half))),
      "restart did not rebase time")

endmodule

`default_nettype wire
